>>> rtl/dds_pkg.sv
// ---------------------------------------------------------------------------
// dds_pkg
// shared types, codes and table functions of the dds sample generator
// ---------------------------------------------------------------------------
package dds_pkg;

  localparam int SAMPLE_BITS = 8;

  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_LOAD    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;
  localparam logic [1:0] OP_UNUSED  = 2'd3;

  localparam logic [1:0] MODE_SINE  = 2'd0;
  localparam logic [1:0] MODE_NOISE = 2'd1;
  localparam logic [1:0] MODE_AM    = 2'd2;
  localparam logic [1:0] MODE_FM    = 2'd3;

  localparam logic [2:0] REG_WAVE_MODE   = 3'd0;
  localparam logic [2:0] REG_CARRIER_INC = 3'd1;
  localparam logic [2:0] REG_MOD_INC     = 3'd2;
  localparam logic [2:0] REG_AM_DEPTH    = 3'd3;
  localparam logic [2:0] REG_AM_SCALE    = 3'd4;
  localparam logic [2:0] REG_FM_DEV      = 3'd5;
  localparam logic [2:0] REG_NOISE_SIGMA = 3'd6;
  localparam logic [2:0] REG_UNUSED      = 3'd7;

  localparam logic [31:0] RNG_SEED  = 32'h9E37_79B9;
  localparam logic [12:0] IH_OFFSET = 13'd1530;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;

  // commands from the sequencer to the datapath
  typedef struct packed {
    logic build;
    logic load;
    logic restart;
    logic addr;
    logic read;
    logic mul1;
    logic mul2;
    logic fmidx;
    logic fmread;
    logic fin;
  } dds_cmd_t;

  typedef struct packed {
    logic build_done;
    logic is_fm;
  } dds_status_t;

  function automatic logic [31:0] xorshift32(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x << 13);
    y = y ^ (y >> 17);
    y = y ^ (y << 5);
    return y;
  endfunction

  function automatic logic [9:0] byte_sum(input logic [31:0] w);
    return 10'(w[7:0]) + 10'(w[15:8]) + 10'(w[23:16]) + 10'(w[31:24]);
  endfunction

  function automatic logic [7:0] clamp_code(input logic signed [15:0] v);
    if (v < 16'sd0) return 8'd0;
    if (v > 16'sd255) return 8'd255;
    return v[7:0];
  endfunction

  function automatic logic [7:0] reverse_code(input logic [7:0] v);
    logic [7:0] r;
    for (int b = 0; b < SAMPLE_BITS; b++) r[SAMPLE_BITS - 1 - b] = v[b];
    return r;
  endfunction

  // sin(2 pi i / depth) in q30, evaluated at elaboration
  function automatic longint sine_q30(input int unsigned I, input int unsigned Depth);
    logic [63:0] t64;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [1:0]  quad;
    longint      s;
    longint      sum;
    t64  = ({32'd0, I} << 32) / Depth;
    quad = t64[31:30];
    r    = {34'd0, t64[29:0]};
    if (quad[0]) r = ONE_Q30 - r;
    if (r == 64'd0) begin
      s = 0;
    end else if (r == ONE_Q30) begin
      s = longint'(ONE_Q30);
    end else begin
      x    = (r * HALF_PI_Q30) >> 30;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int k = 1; k < 12; k++) begin
        term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
        if (k % 2 == 1) sum = sum - longint'(term);
        else sum = sum + longint'(term);
      end
      if (sum < 0) sum = 0;
      if (sum > longint'(ONE_Q30)) sum = longint'(ONE_Q30);
      s = sum;
    end
    return quad[1] ? -s : s;
  endfunction

  function automatic logic [7:0] sine_code_entry(input int unsigned I,
                                                 input int unsigned Depth);
    longint      s;
    logic [63:0] u;
    s = sine_q30(I, Depth);
    u = 64'(longint'(ONE_Q30) + s);
    return 8'((64'd255 * u) >> 31);
  endfunction

  function automatic logic [7:0] signed_sine_entry(input int unsigned I,
                                                   input int unsigned Depth);
    longint s;
    longint mag;
    longint raw;
    s   = sine_q30(I, Depth);
    mag = (s < 0) ? -s : s;
    raw = (127 * mag) >>> 30;
    return 8'((s < 0) ? -raw : raw);
  endfunction

endpackage

>>> rtl/dds_ctrl.sv
// ---------------------------------------------------------------------------
// dds_ctrl
// sequencer: table build sweep, request decode and per-sample steps
// ---------------------------------------------------------------------------
module dds_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          opcode,
  input  logic                out_free,
  input  dds_pkg::dds_status_t status,
  output dds_pkg::dds_cmd_t   cmd
);

  typedef enum logic [8:0] {
    S_BUILD  = 9'b000000001,
    S_IDLE   = 9'b000000010,
    S_ADDR   = 9'b000000100,
    S_READ   = 9'b000001000,
    S_MUL1   = 9'b000010000,
    S_MUL2   = 9'b000100000,
    S_FMIDX  = 9'b001000000,
    S_FMREAD = 9'b010000000,
    S_FIN    = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);

  always_comb begin
    cmd         = '0;
    cmd.build   = (state == S_BUILD);
    cmd.load    = accept && (opcode == dds_pkg::OP_LOAD);
    cmd.restart = accept && (opcode == dds_pkg::OP_RESTART);
    cmd.addr    = (state == S_ADDR);
    cmd.read    = (state == S_READ);
    cmd.mul1    = (state == S_MUL1);
    cmd.mul2    = (state == S_MUL2);
    cmd.fmidx   = (state == S_FMIDX);
    cmd.fmread  = (state == S_FMREAD);
    cmd.fin     = (state == S_FIN) && out_free;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_BUILD:  if (status.build_done) state_next = S_IDLE;
      S_IDLE:   if (accept && opcode == dds_pkg::OP_TICK) state_next = S_ADDR;
      S_ADDR:   state_next = S_READ;
      S_READ:   state_next = S_MUL1;
      S_MUL1:   state_next = S_MUL2;
      S_MUL2:   state_next = status.is_fm ? S_FMIDX : S_FIN;
      S_FMIDX:  state_next = S_FMREAD;
      S_FMREAD: state_next = S_FIN;
      S_FIN:    if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_BUILD;
    else state <= state_next;
  end

endmodule

>>> rtl/dds_datapath.sv
// ---------------------------------------------------------------------------
// dds_datapath
// phase accumulators, sine tables, noise memories, multipliers and output
// ---------------------------------------------------------------------------
module dds_datapath #(
  parameter int WAVE_TABLE_DEPTH  = 256,
  parameter int GAUSS_TABLE_DEPTH = 65536
) (
  input  logic                clk,
  input  logic                rst,
  input  dds_pkg::dds_cmd_t   cmd,
  output dds_pkg::dds_status_t status,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic [7:0]          entry_index,
  input  logic signed [7:0]   entry_value,
  output logic                out_free,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          sample_code,
  output logic [7:0]          pin_code
);

  localparam int IW = $clog2(WAVE_TABLE_DEPTH);
  localparam int GW = $clog2(GAUSS_TABLE_DEPTH);
  localparam logic [IW:0] WDEP = (IW + 1)'(WAVE_TABLE_DEPTH);
  localparam logic [GW:0] GDEP = (GW + 1)'(GAUSS_TABLE_DEPTH);

  // configuration
  logic [1:0]  wave_mode;
  logic [31:0] carrier_inc;
  logic [31:0] mod_inc;
  logic [7:0]  am_depth;
  logic [7:0]  am_scale;
  logic [19:0] fm_dev;
  logic [12:0] noise_sigma;

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_mode   <= dds_pkg::MODE_SINE;
      carrier_inc <= 32'd1064469;
      mod_inc     <= 32'd1064469;
      am_depth    <= 8'd64;
      am_scale    <= 8'd85;
      fm_dev      <= 20'd415;
      noise_sigma <= 13'd1792;
    end else if (cfg_we) begin
      case (cfg_index)
        dds_pkg::REG_WAVE_MODE:   wave_mode   <= cfg_data[1:0];
        dds_pkg::REG_CARRIER_INC: carrier_inc <= cfg_data;
        dds_pkg::REG_MOD_INC:     mod_inc     <= cfg_data;
        dds_pkg::REG_AM_DEPTH:    am_depth    <= cfg_data[7:0];
        dds_pkg::REG_AM_SCALE:    am_scale    <= cfg_data[7:0];
        dds_pkg::REG_FM_DEV:      fm_dev      <= cfg_data[19:0];
        dds_pkg::REG_NOISE_SIGMA: noise_sigma <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // constant sine tables
  logic [7:0] code_tab [WAVE_TABLE_DEPTH];
  logic [7:0] sig_tab  [WAVE_TABLE_DEPTH];

  for (genvar g = 0; g < WAVE_TABLE_DEPTH; g++) begin : g_tab
    assign code_tab[g] = dds_pkg::sine_code_entry(g, WAVE_TABLE_DEPTH);
    assign sig_tab[g]  = dds_pkg::signed_sine_entry(g, WAVE_TABLE_DEPTH);
  end

  // gauss memory, filled by the build sweep
  logic signed [11:0] gauss_mem [GAUSS_TABLE_DEPTH];
  logic [GW-1:0]      build_cnt;
  logic [31:0]        rng;
  logic [31:0]        draw_a;
  logic [31:0]        draw_b;
  logic [31:0]        draw_c;
  logic [11:0]        draw_sum;
  logic [31:0]        tick_word;

  assign draw_a   = dds_pkg::xorshift32(rng);
  assign draw_b   = dds_pkg::xorshift32(draw_a);
  assign draw_c   = dds_pkg::xorshift32(draw_b);
  assign draw_sum = 12'(dds_pkg::byte_sum(draw_a)) + 12'(dds_pkg::byte_sum(draw_b))
                  + 12'(dds_pkg::byte_sum(draw_c)) - 12'(dds_pkg::IH_OFFSET);
  assign tick_word = dds_pkg::xorshift32(rng);

  assign status.build_done = cmd.build && (build_cnt == GW'(GAUSS_TABLE_DEPTH - 1));
  assign status.is_fm      = (wave_mode == dds_pkg::MODE_FM);

  always_ff @(posedge clk) begin
    if (cmd.build) gauss_mem[build_cnt] <= $signed(draw_sum);
  end

  // noise-sine store, no reset
  logic signed [7:0] store_mem [WAVE_TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (cmd.load && (32'(entry_index) < 32'(WAVE_TABLE_DEPTH)))
      store_mem[IW'(entry_index)] <= entry_value;
  end

  // phase accumulators
  logic [31:0] carrier_phase;
  logic [31:0] mod_accum;
  logic [31:0] fm_accum;

  // pipeline registers
  logic [IW-1:0]      idx_a;
  logic [IW-1:0]      idx_b;
  logic [GW-1:0]      gidx;
  logic [7:0]         code_r;
  logic signed [7:0]  sc_r;
  logic signed [7:0]  sm_r;
  logic signed [7:0]  st_r;
  logic signed [11:0] g_r;
  logic signed [16:0] prod_a;
  logic signed [16:0] prod_env;
  logic signed [28:0] prod_dev;
  logic signed [25:0] prod_g;
  logic signed [27:0] am_prod;
  logic signed [10:0] noise_r;

  logic [32+IW:0]     ca_prod;
  logic [32+IW:0]     mb_prod;
  logic [32+IW:0]     fm_prod;
  logic [16+GW:0]     g_idx_prod;
  logic signed [10:0] env;
  logic signed [26:0] g_round;
  logic signed [27:0] am_round;
  logic signed [13:0] am_val;
  logic signed [15:0] v;
  logic [7:0]         code;

  assign ca_prod    = (33 + IW)'(carrier_phase) * (33 + IW)'(WDEP);
  assign mb_prod    = (33 + IW)'(mod_accum) * (33 + IW)'(WDEP);
  assign fm_prod    = (33 + IW)'(fm_accum) * (33 + IW)'(WDEP);
  assign g_idx_prod = (17 + GW)'(tick_word[31:16]) * (17 + GW)'(GDEP);
  assign env        = 11'sd128 + 11'(prod_env >>> 7);
  assign g_round    = 27'(prod_g) + 27'sd32768;
  assign am_round   = am_prod + 28'sd8192;
  assign am_val     = 14'(am_round >>> 14);

  always_ff @(posedge clk) begin
    if (rst) begin
      build_cnt     <= '0;
      rng           <= dds_pkg::RNG_SEED;
      carrier_phase <= '0;
      mod_accum     <= '0;
      fm_accum      <= '0;
    end else begin
      if (cmd.build) begin
        build_cnt <= build_cnt + GW'(1);
        rng       <= draw_c;
      end
      if (cmd.addr && wave_mode == dds_pkg::MODE_NOISE) rng <= tick_word;
      if (cmd.restart) begin
        carrier_phase <= '0;
        mod_accum     <= '0;
        fm_accum      <= '0;
      end
      if (cmd.mul2 && wave_mode == dds_pkg::MODE_FM)
        fm_accum <= fm_accum + carrier_inc + {{3{prod_dev[28]}}, prod_dev};
      if (cmd.fin) begin
        if (wave_mode != dds_pkg::MODE_FM) carrier_phase <= carrier_phase + carrier_inc;
        if (wave_mode == dds_pkg::MODE_AM || wave_mode == dds_pkg::MODE_FM)
          mod_accum <= mod_accum + mod_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.addr) begin
      idx_a <= ca_prod[32 +: IW];
      idx_b <= mb_prod[32 +: IW];
      gidx  <= g_idx_prod[16 +: GW];
    end
    if (cmd.read) begin
      code_r <= code_tab[idx_a];
      sc_r   <= $signed(sig_tab[idx_a]);
      sm_r   <= $signed(sig_tab[idx_b]);
      st_r   <= store_mem[idx_a];
      g_r    <= gauss_mem[gidx];
    end
    if (cmd.mul1) begin
      prod_a   <= sc_r * $signed({1'b0, am_scale});
      prod_env <= $signed({1'b0, am_depth}) * sm_r;
      prod_dev <= $signed({1'b0, fm_dev}) * sm_r;
      prod_g   <= g_r * $signed({1'b0, noise_sigma});
    end
    if (cmd.mul2) begin
      am_prod <= 28'(prod_a * env);
      noise_r <= 11'(g_round >>> 16);
    end
    if (cmd.fmidx) idx_a <= fm_prod[32 +: IW];
    if (cmd.fmread) sc_r <= $signed(sig_tab[idx_a]);
  end

  always_comb begin
    case (wave_mode)
      dds_pkg::MODE_NOISE: v = 16'sd128 + 16'(st_r) + 16'(noise_r);
      dds_pkg::MODE_AM:    v = 16'sd128 + 16'(am_val);
      dds_pkg::MODE_FM:    v = 16'sd128 + 16'(sc_r);
      default:             v = $signed({8'd0, code_r});
    endcase
    code = dds_pkg::clamp_code(v);
  end

  // output register
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.fin) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      sample_code <= code;
      pin_code    <= dds_pkg::reverse_code(code);
    end
  end

endmodule

>>> rtl/dds_waveform_sample_generator.sv
// ---------------------------------------------------------------------------
// dds_waveform_sample_generator
// phase accumulator dds giving one 8-bit dac sample per tick request
// ---------------------------------------------------------------------------
// After reset the block fills its gaussian noise table (one entry per cycle
// from three xorshift draws) and holds in_stall high meanwhile; configuration
// writes are taken during that time. A load or restart request leaves the
// block idle. A tick request runs through a five-step sequence (address,
// table read, two multiply stages, result) and the next request is taken
// once the sequence is back in idle; in fm mode, where the carrier index
// depends on the product of the deviation and the modulator sine, an index
// step and a second table read come before the result. The result step
// waits while the output register holds a stalled sample; the result then
// sits in that register, so a new request is taken while the previous sample
// still waits. Opcode 3 is dropped; loads and restarts give no sample.
// ---------------------------------------------------------------------------
module dds_waveform_sample_generator #(
  parameter int WAVE_TABLE_DEPTH  = 256,
  parameter int GAUSS_TABLE_DEPTH = 65536
) (
  input  logic              clk,
  input  logic              rst,
  // request channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        opcode,
  input  logic [7:0]        entry_index,
  input  logic signed [7:0] entry_value,
  // sample channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        sample_code,
  output logic [7:0]        pin_code,
  // register writes
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data
);

  dds_pkg::dds_cmd_t    cmd;
  dds_pkg::dds_status_t status;
  logic                 out_free;

  // sequencer
  dds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .opcode   (opcode),
    .out_free (out_free),
    .status   (status),
    .cmd      (cmd)
  );

  // phases, tables, arithmetic and output register
  dds_datapath #(
    .WAVE_TABLE_DEPTH  (WAVE_TABLE_DEPTH),
    .GAUSS_TABLE_DEPTH (GAUSS_TABLE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .entry_index (entry_index),
    .entry_value (entry_value),
    .out_free    (out_free),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .sample_code (sample_code),
    .pin_code    (pin_code)
  );

  // at most one sequence step active at a time
  a_one_step: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.build, cmd.addr, cmd.read, cmd.mul1, cmd.mul2,
              cmd.fmidx, cmd.fmread, cmd.fin}))
    else $error("more than one sequence step active");

  // no request taken while the noise table is being built
  a_no_accept_in_build: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |-> !cmd.build)
    else $error("request taken during table build");

  // a finished sample shows up on the output
  a_fin_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |=> out_valid)
    else $error("finished sample not presented");

  // the fm index step follows the second multiply step
  a_fm_order: assert property (@(posedge clk) disable iff (rst)
    cmd.fmidx |-> $past(cmd.mul2))
    else $error("fm index step out of order");

endmodule
